[hdl/cwjs_pkg.sv]
// Shared types and constants for the checkpointed write journal sorter.
package cwjs_pkg;

   localparam int MaxWrites      = 64;
   localparam int MaxCheckpoints = 16;
   localparam int CountWidth     = $clog2(MaxWrites + 1);
   localparam int IndexWidth     = $clog2(MaxWrites);
   localparam int DepthWidth     = $clog2(MaxCheckpoints + 1);
   localparam int StackWidth     = (MaxCheckpoints > 1) ? $clog2(MaxCheckpoints) : 1;
   localparam int PhaseWidth     = $clog2(MaxWrites);
   localparam logic [31:0] ProtocolId = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_START      = 3'd0,
      OP_CHECKPOINT = 3'd1,
      OP_WRITE      = 3'd2,
      OP_COMMIT     = 3'd3,
      OP_REVERT     = 3'd4,
      OP_END        = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_EMIT
   } state_type;

   // One journal entry as held by a cell.
   typedef struct packed {
      logic         valid;
      logic [255:0] slot;
      logic [31:0]  id;
   } entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic load;
      logic mark;
      logic mark_valid;
      logic sort_lower;
      logic sort_upper;
      logic shift;
   } cell_ctrl_type;

endpackage

[hdl/cwjs_cell.sv]
// One cell of the journal chain: holds an entry, sorts against its neighbours and shifts.
module cwjs_cell (
   input  logic                    clock,
   input  cwjs_pkg::cell_ctrl_type ctrl,
   input  cwjs_pkg::entry_type     load_entry,
   input  cwjs_pkg::entry_type     lower_entry,
   input  cwjs_pkg::entry_type     upper_entry,
   input  logic                    swap_in,
   output logic                    swap_out,
   output cwjs_pkg::entry_type     entry
);
   import cwjs_pkg::*;

   entry_type entry_ff, entry_in;
   logic      upper_first;

   // The upper neighbour sorts strictly before this entry; empty entries sort last.
   assign upper_first = upper_entry.valid &&
                        (!entry_ff.valid ||
                         ({upper_entry.slot, upper_entry.id} < {entry_ff.slot, entry_ff.id}));
   assign swap_out = ctrl.sort_lower && upper_first;

   // Next entry value.
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.load) begin
         entry_in = load_entry;
      end else if (ctrl.mark) begin
         entry_in.valid = ctrl.mark_valid;
      end else if (ctrl.shift) begin
         entry_in = upper_entry;
      end else if (swap_out) begin
         entry_in = upper_entry;
      end else if (ctrl.sort_upper && swap_in) begin
         entry_in = lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[hdl/checkpointed_write_journal_sorter.sv]
// Top level of the checkpointed write journal sorter: sequencer, checkpoint stack and cell chain.
//
//   channel   direction  contents
//   req_*     in         one journal operation with its slot key and id
//   rsp_*     out        one sorted write, with last and error flags
//
// Start, checkpoint, write, commit and revert are handled in the idle state. End runs
// odd-even transposition over the cell chain (when the journal is not empty), then gives
// one result per cycle as rsp_ready allows; no request is taken until the run is out.
// Reset clears the journal length, the checkpoint depth and the error flag.
// A stalled result holds in the first cell until it is taken.
module checkpointed_write_journal_sorter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_operation,
   input  logic [63:0] req_slot_word_0,
   input  logic [63:0] req_slot_word_1,
   input  logic [63:0] req_slot_word_2,
   input  logic [63:0] req_slot_word_3,
   input  logic        req_protocol_write,
   input  logic [31:0] req_execution_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_out_slot_word_0,
   output logic [63:0] rsp_out_slot_word_1,
   output logic [63:0] rsp_out_slot_word_2,
   output logic [63:0] rsp_out_slot_word_3,
   output logic [31:0] rsp_out_execution_id,
   output logic        rsp_last_write,
   output logic        rsp_error_seen
);
   import cwjs_pkg::*;

   state_type              state_ff, state_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [DepthWidth-1:0]  depth_ff, depth_in;
   logic                   error_ff, error_in;
   logic [PhaseWidth-1:0]  phase_ff, phase_in;
   logic [CountWidth-1:0]  remain_ff, remain_in;
   logic [CountWidth-1:0]  mark_stack_ff [MaxCheckpoints];
   logic [StackWidth-1:0]  top_index;
   logic [CountWidth-1:0]  top_mark;
   logic                   accept, push, rsp_take;
   entry_type              load_entry;
   entry_type              entries [MaxWrites];
   logic                   swaps [MaxWrites];

   assign accept   = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;
   assign push     = accept && (req_operation == OP_CHECKPOINT) &&
                     (depth_ff < DepthWidth'(MaxCheckpoints));
   assign top_index = StackWidth'(depth_ff - DepthWidth'(1));
   assign top_mark  = mark_stack_ff[top_index];

   assign load_entry.valid = 1'b1;
   assign load_entry.slot  = {req_slot_word_3, req_slot_word_2, req_slot_word_1, req_slot_word_0};
   assign load_entry.id    = req_protocol_write ? ProtocolId : req_execution_id;

   // Sequencer: journal bookkeeping, sort phases and emission.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      depth_in  = depth_ff;
      error_in  = error_ff;
      phase_in  = phase_ff;
      remain_in = remain_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_operation)
                  OP_START: begin
                     count_in = '0;
                     depth_in = '0;
                     error_in = 1'b0;
                  end
                  OP_CHECKPOINT: begin
                     if (push) depth_in = depth_ff + DepthWidth'(1);
                     else      error_in = 1'b1;
                  end
                  OP_WRITE: begin
                     if (count_ff < CountWidth'(MaxWrites)) count_in = count_ff + CountWidth'(1);
                     else                                   error_in = 1'b1;
                  end
                  OP_COMMIT: begin
                     if (depth_ff != '0) depth_in = depth_ff - DepthWidth'(1);
                  end
                  OP_REVERT: begin
                     if (depth_ff != '0) begin
                        depth_in = depth_ff - DepthWidth'(1);
                        if (top_mark < count_ff) count_in = top_mark;
                     end
                  end
                  OP_END: begin
                     remain_in = count_ff;
                     count_in  = '0;
                     depth_in  = '0;
                     phase_in  = '0;
                     if (count_ff != '0) state_in = ST_SORT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SORT: begin
            phase_in = phase_ff + PhaseWidth'(1);
            if (phase_ff == PhaseWidth'(MaxWrites - 1)) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_take) begin
               remain_in = remain_ff - CountWidth'(1);
               if (remain_ff == CountWidth'(1)) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         depth_ff  <= '0;
         error_ff  <= 1'b0;
         phase_ff  <= '0;
         remain_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         depth_ff  <= depth_in;
         error_ff  <= error_in;
         phase_ff  <= phase_in;
         remain_ff <= remain_in;
      end
   end

   // Checkpoint stack of journal lengths.
   always_ff @(posedge clock) begin
      if (push) mark_stack_ff[StackWidth'(depth_ff)] <= count_ff;
   end

   // Cell chain; cell 0 holds the smallest entry once sorted.
   for (genvar i = 0; i < MaxWrites; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     lower_entry, upper_entry;
      logic          swap_in;

      assign ctrl.load = accept && (req_operation == OP_WRITE) &&
                         (count_ff == CountWidth'(i));
      assign ctrl.mark = accept && (req_operation == OP_END);
      assign ctrl.mark_valid = CountWidth'(i) < count_ff;
      assign ctrl.sort_lower = (state_ff == ST_SORT) && (i < MaxWrites - 1) &&
                               (((i % 2) == 1) == phase_ff[0]);
      assign ctrl.sort_upper = (state_ff == ST_SORT) && (i > 0) &&
                               (((i % 2) == 1) != phase_ff[0]);
      assign ctrl.shift = rsp_take;

      if (i == 0) begin : g_first
         assign lower_entry = '0;
         assign swap_in     = 1'b0;
      end else begin : g_inner
         assign lower_entry = entries[i-1];
         assign swap_in     = swaps[i-1];
      end
      if (i == MaxWrites - 1) begin : g_last
         assign upper_entry = '0;
      end else begin : g_below
         assign upper_entry = entries[i+1];
      end

      cwjs_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .load_entry  (load_entry),
         .lower_entry (lower_entry),
         .upper_entry (upper_entry),
         .swap_in     (swap_in),
         .swap_out    (swaps[i]),
         .entry       (entries[i])
      );
   end

   // Result comes straight from the head of the chain.
   assign rsp_valid            = (state_ff == ST_EMIT);
   assign rsp_out_slot_word_0  = entries[0].slot[63:0];
   assign rsp_out_slot_word_1  = entries[0].slot[127:64];
   assign rsp_out_slot_word_2  = entries[0].slot[191:128];
   assign rsp_out_slot_word_3  = entries[0].slot[255:192];
   assign rsp_out_execution_id = entries[0].id;
   assign rsp_last_write       = (remain_ff == CountWidth'(1));
   assign rsp_error_seen       = error_ff;

endmodule
